// ===== hw/rtl/vlc_integer_stream_decoder_core_defines.svh =====
// Assertion macros for the compact integer stream decoder.
// Used by the port checker; depends on nothing else.
`ifndef VLC_INTEGER_STREAM_DECODER_CORE_DEFINES_SVH
`define VLC_INTEGER_STREAM_DECODER_CORE_DEFINES_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define VID_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define VID_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/vid_pkg.sv =====
// Shared types and constants of the compact integer stream decoder.
// No dependencies; imported by every RTL module of the block.
`default_nettype none

package vid_pkg;

   // Largest number of data bytes behind a long-form lead byte.
   localparam int MaxDataBytes = 8;

   // Depth of the work queue and of the result queue.
   localparam int QueueDepth = 2;
   localparam int QPtrBits   = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
   localparam int QCountBits = $clog2(QueueDepth + 1);

   localparam logic [7:0] LeadNull  = 8'hC0;
   localparam logic [5:0] LeadMaxN  = 6'(MaxDataBytes);

   localparam logic [63:0] ExtMaskShort = 64'hffff_ffff_ffff_ffc0;
   localparam logic [63:0] ExtMaskPair  = 64'hffff_ffff_ffff_c000;

   // Value type codes
   localparam logic [3:0] VT_BOOL = 4'd0;
   localparam logic [3:0] VT_U8   = 4'd1;
   localparam logic [3:0] VT_U16  = 4'd2;
   localparam logic [3:0] VT_U32  = 4'd3;
   localparam logic [3:0] VT_U64  = 4'd4;
   localparam logic [3:0] VT_I8   = 4'd5;
   localparam logic [3:0] VT_I16  = 4'd6;
   localparam logic [3:0] VT_I32  = 4'd7;
   localparam logic [3:0] VT_I64  = 4'd8;

   typedef enum logic [2:0] {
      ST_OK    = 3'd0,
      ST_RANGE = 3'd1,
      ST_BOOL  = 3'd2,
      ST_LEAD  = 3'd3,
      ST_TRUNC = 3'd4
   } vid_status_type;

   // Where the sign bit of a finished value sits.
   typedef enum logic [1:0] {
      EXT_NONE,
      EXT_SHORT,
      EXT_PAIR,
      EXT_LONG
   } vid_ext_type;

   typedef enum logic [1:0] {
      FS_LEAD,
      FS_PAIR,
      FS_LONG
   } vid_front_state_type;

   // Classified request handed from front to back.
   typedef struct packed {
      logic [63:0]    raw;
      vid_ext_type    ext;
      logic [3:0]     ext_bytes;
      logic [3:0]     vtype;
      logic           is_null;
      vid_status_type status;
      logic [3:0]     consumed;
   } vid_work_type;

   typedef struct packed {
      logic [63:0]    value;
      logic           is_null;
      vid_status_type status;
      logic [3:0]     consumed;
   } vid_result_type;

endpackage

`default_nettype wire

// ===== hw/rtl/vid_work_queue.sv =====
// Short queue of classified requests between front and back.
// Depends on vid_pkg.
`default_nettype none

module vid_work_queue
   import vid_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         push,
   input  wire vid_work_type push_data,
   output logic              full,
   output logic              valid,
   input  wire logic         pop,
   output vid_work_type      head
);

   vid_work_type            mem_ff [QueueDepth];
   logic [QPtrBits-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [QPtrBits-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [QCountBits-1:0]   count_ff, count_in;
   logic                    do_push, do_pop;

   assign full    = (count_ff == QCountBits'(QueueDepth));
   assign valid   = (count_ff != '0);
   assign head    = mem_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPtrBits'(QueueDepth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPtrBits'(QueueDepth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/vid_front.sv =====
// Front end: parses lead bytes, gathers data bytes, classifies each request.
// Depends on vid_pkg.
`default_nettype none

module vid_front
   import vid_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         take,
   input  wire logic [7:0]   in_byte,
   input  wire logic [3:0]   value_type,
   input  wire logic         buffer_end,
   output logic              emit,
   output vid_work_type      work
);

   vid_front_state_type state_ff, state_in;
   logic [3:0]          remaining_ff, remaining_in;
   logic [3:0]          seen_ff, seen_in;
   logic [63:0]         asm_ff, asm_in;
   logic [3:0]          type_ff, type_in;

   logic [5:0]          lead_n;
   logic [2:0]          pos;
   logic [63:0]         data_asm;
   logic [3:0]          seen_next;
   logic [3:0]          remaining_next;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FS_LEAD;
         remaining_ff <= '0;
         seen_ff      <= '0;
         type_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         remaining_ff <= remaining_in;
         seen_ff      <= seen_in;
         type_ff      <= type_in;
      end
   end

   always_ff @(posedge clock) begin
      asm_ff <= asm_in;
   end

   // Data byte lands in the byte lane given by the bytes already seen.
   always_comb begin
      lead_n         = in_byte[5:0];
      pos            = seen_ff[2:0] - 3'd1;
      seen_next      = seen_ff + 4'd1;
      remaining_next = remaining_ff - 4'd1;
      for (int k = 0; k < 8; k++) begin
         data_asm[k*8 +: 8] = asm_ff[k*8 +: 8] | ((pos == 3'(k)) ? in_byte : 8'h00);
      end
   end

   always_comb begin
      state_in     = state_ff;
      remaining_in = remaining_ff;
      seen_in      = seen_ff;
      asm_in       = asm_ff;
      type_in      = type_ff;
      emit         = 1'b0;
      work         = '0;
      work.ext     = EXT_NONE;
      work.status  = ST_OK;
      if (take) begin
         unique case (state_ff)
            FS_LEAD: begin
               type_in       = value_type;
               work.consumed = 4'd1;
               work.vtype    = value_type;
               if (!in_byte[7]) begin
                  emit     = 1'b1;
                  work.raw = {57'b0, in_byte[6:0]};
                  work.ext = EXT_SHORT;
               end else if (in_byte == LeadNull) begin
                  emit         = 1'b1;
                  work.is_null = 1'b1;
               end else if (buffer_end) begin
                  emit        = 1'b1;
                  work.status = ST_TRUNC;
               end else if (!in_byte[6]) begin
                  state_in     = FS_PAIR;
                  remaining_in = 4'd1;
                  seen_in      = 4'd1;
                  asm_in       = {58'b0, in_byte[5:0]};
               end else if (lead_n > LeadMaxN) begin
                  emit        = 1'b1;
                  work.status = ST_LEAD;
               end else begin
                  state_in     = FS_LONG;
                  remaining_in = lead_n[3:0];
                  seen_in      = 4'd1;
                  asm_in       = '0;
               end
            end
            FS_PAIR: begin
               emit          = 1'b1;
               work.raw      = asm_ff | {50'b0, in_byte, 6'b0};
               work.ext      = EXT_PAIR;
               work.vtype    = type_ff;
               work.consumed = 4'd2;
               state_in      = FS_LEAD;
            end
            FS_LONG: begin
               asm_in       = data_asm;
               seen_in      = seen_next;
               remaining_in = remaining_next;
               work.vtype   = type_ff;
               if (remaining_next == 4'd0) begin
                  emit           = 1'b1;
                  work.raw       = data_asm;
                  work.ext       = EXT_LONG;
                  work.ext_bytes = seen_ff;
                  work.consumed  = seen_next;
                  state_in       = FS_LEAD;
               end else if (buffer_end) begin
                  emit          = 1'b1;
                  work.status   = ST_TRUNC;
                  work.consumed = seen_next;
                  state_in      = FS_LEAD;
               end
            end
            default: begin
               state_in = FS_LEAD;
            end
         endcase
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/vid_back.sv =====
// Back end: sign extension, range check, and the result queue.
// Depends on vid_pkg.
`default_nettype none

module vid_back
   import vid_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         work_valid,
   input  wire vid_work_type work,
   output logic              work_pop,
   output logic              out_empty,
   input  wire logic         out_pop,
   output vid_result_type    out_head
);

   vid_result_type          mem_ff [QueueDepth];
   logic [QPtrBits-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [QPtrBits-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [QCountBits-1:0]   count_ff, count_in;
   logic                    do_pop;

   logic                    is_signed;
   logic                    top_bit;
   logic [5:0]              top_idx;
   logic [5:0]              long_shift;
   logic [63:0]             ext_mask;
   logic [63:0]             value;
   vid_status_type          range_st;
   vid_result_type          result;

   assign work_pop  = work_valid && (count_ff != QCountBits'(QueueDepth));
   assign out_empty = (count_ff == '0);
   assign out_head  = mem_ff[rd_ptr_ff];
   assign do_pop    = out_pop && !out_empty;

   always_comb begin
      case (work.vtype) inside
         VT_I8, VT_I16, VT_I32, VT_I64: is_signed = 1'b1;
         default:                       is_signed = 1'b0;
      endcase
   end

   // Sign bit and fill mask by form; long form of 8 bytes needs no fill.
   always_comb begin
      long_shift = {work.ext_bytes[2:0], 3'b000};
      top_idx    = long_shift - 6'd1;
      top_bit    = 1'b0;
      ext_mask   = '0;
      unique case (work.ext)
         EXT_SHORT: begin
            top_bit  = work.raw[6];
            ext_mask = ExtMaskShort;
         end
         EXT_PAIR: begin
            top_bit  = work.raw[13];
            ext_mask = ExtMaskPair;
         end
         EXT_LONG: begin
            top_bit  = !work.ext_bytes[3] && work.raw[top_idx];
            ext_mask = {64{1'b1}} << long_shift;
         end
         default: begin
            top_bit = 1'b0;
         end
      endcase
      value = work.raw | ((is_signed && top_bit) ? ext_mask : 64'd0);
   end

   // Signed fits when every bit above the top data bit equals it.
   always_comb begin
      range_st = ST_OK;
      unique case (work.vtype)
         VT_BOOL: begin
            if (value[63:8] != '0) begin
               range_st = ST_RANGE;
            end else if (value[7:1] != '0) begin
               range_st = ST_BOOL;
            end
         end
         VT_U8:  range_st = (value[63:8]  != '0) ? ST_RANGE : ST_OK;
         VT_U16: range_st = (value[63:16] != '0) ? ST_RANGE : ST_OK;
         VT_U32: range_st = (value[63:32] != '0) ? ST_RANGE : ST_OK;
         VT_I8:  range_st = (value[63:7]  != '0 && value[63:7]  != '1) ? ST_RANGE : ST_OK;
         VT_I16: range_st = (value[63:15] != '0 && value[63:15] != '1) ? ST_RANGE : ST_OK;
         VT_I32: range_st = (value[63:31] != '0 && value[63:31] != '1) ? ST_RANGE : ST_OK;
         default: range_st = ST_OK;
      endcase
   end

   always_comb begin
      result.value    = value;
      result.is_null  = work.is_null;
      result.status   = (work.status == ST_OK) ? range_st : work.status;
      result.consumed = work.consumed;
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (work_pop) begin
         wr_ptr_in = (wr_ptr_ff == QPtrBits'(QueueDepth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPtrBits'(QueueDepth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (work_pop && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !work_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (work_pop) begin
         mem_ff[wr_ptr_ff] <= result;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/vlc_integer_stream_decoder_core.sv =====
// Compact integer stream decoder: takes one encoded byte per request and
// returns one decoded value per finished integer (short, two-byte, null or
// long form), with null flag, status and byte count. Throughput is one request
// per clock while req_full stays low, since the front parser handles each byte
// as it is taken. A result reaches the rsp_ ports by way of the work queue,
// then through the back end into the result queue, and a full result queue
// can hold it back. Both queues hold two entries, so a stall on the result side
// reaches req_full after the two queues fill. Bytes that finish no value give
// no result.
// Depends on vid_pkg, vid_front, vid_work_queue, vid_back.
`default_nettype none

module vlc_integer_stream_decoder_core
   import vid_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   // request side
   input  wire logic         req_push,
   output logic              req_full,
   input  wire logic [7:0]   req_in_byte,
   input  wire logic [3:0]   req_value_type,
   input  wire logic         req_buffer_end,
   // result side
   output logic              rsp_empty,
   input  wire logic         rsp_pop,
   output logic [63:0]       rsp_decoded_value,
   output logic              rsp_is_null,
   output logic [2:0]        rsp_status,
   output logic [3:0]        rsp_consumed_bytes
);

   logic            take;
   logic            front_emit;
   vid_work_type    front_work;
   logic            work_valid;
   logic            work_pop;
   vid_work_type    work_head;
   vid_result_type  out_head;

   // A request is taken only while the work queue has room, so every
   // request the front classifies is guaranteed a slot.
   assign take = req_push && !req_full;

   vid_front u_front (
      .clock      (clock),
      .reset      (reset),
      .take       (take),
      .in_byte    (req_in_byte),
      .value_type (req_value_type),
      .buffer_end (req_buffer_end),
      .emit       (front_emit),
      .work       (front_work)
   );

   vid_work_queue u_work_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (front_emit),
      .push_data (front_work),
      .full      (req_full),
      .valid     (work_valid),
      .pop       (work_pop),
      .head      (work_head)
   );

   // Back end drains the work queue whenever its result queue has room.
   vid_back u_back (
      .clock      (clock),
      .reset      (reset),
      .work_valid (work_valid),
      .work       (work_head),
      .work_pop   (work_pop),
      .out_empty  (rsp_empty),
      .out_pop    (rsp_pop),
      .out_head   (out_head)
   );

   assign rsp_decoded_value  = out_head.value;
   assign rsp_is_null        = out_head.is_null;
   assign rsp_status         = out_head.status;
   assign rsp_consumed_bytes = out_head.consumed;

endmodule

`default_nettype wire

// ===== hw/rtl/vid_checker.sv =====
// Port-level checker for the compact integer stream decoder, bound to the top.
// Depends on vid_pkg and vlc_integer_stream_decoder_core_defines.svh.
`default_nettype none

`include "vlc_integer_stream_decoder_core_defines.svh"

module vid_checker
   import vid_pkg::*;
(
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         rsp_empty,
   input wire logic         rsp_pop,
   input wire logic [63:0]  rsp_decoded_value,
   input wire logic         rsp_is_null,
   input wire logic [2:0]   rsp_status,
   input wire logic [3:0]   rsp_consumed_bytes
);

   // Null result is a one-byte zero with good status.
   `VID_ASSERT_NOW(a_null_shape, clock, reset, !rsp_empty && rsp_is_null, rsp_decoded_value == 64'd0 && rsp_status == ST_OK && rsp_consumed_bytes == 4'd1, "null result malformed")

   // Lead-length and truncation errors carry a zero value.
   `VID_ASSERT_NOW(a_err_zero, clock, reset, !rsp_empty && (rsp_status == ST_LEAD || rsp_status == ST_TRUNC), rsp_decoded_value == 64'd0 && !rsp_is_null, "error result has value")

   // Bad boolean means a value from 2 to 255.
   `VID_ASSERT_NOW(a_bool_span, clock, reset, !rsp_empty && rsp_status == ST_BOOL, rsp_decoded_value[63:8] == 56'd0 && rsp_decoded_value[7:1] != 7'd0, "bad boolean out of span")

   // Byte count lies in 1..9; a bad lead is always a single byte.
   `VID_ASSERT_NOW(a_count, clock, reset, !rsp_empty, rsp_consumed_bytes != 4'd0 && rsp_consumed_bytes <= 4'd9 && (rsp_status != ST_LEAD || rsp_consumed_bytes == 4'd1), "byte count off")

   // A waiting result holds until taken.
   `VID_ASSERT_NEXT(a_hold, clock, reset, !rsp_empty && !rsp_pop, !rsp_empty && $stable(rsp_decoded_value) && $stable(rsp_status), "result dropped or changed")

endmodule

bind vlc_integer_stream_decoder_core vid_checker u_vid_checker (.*);

`default_nettype wire

// ===== dv/vid_decode_checker.sv =====
// Checker for the compact integer stream decoder: watches both queue ports,
// predicts each decoded value from the accepted bytes and compares in order.
// Depends on vid_pkg for the type codes, status codes and result struct.

module vid_decode_checker
   import vid_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   input  logic        req_full,
   input  logic [7:0]  req_in_byte,
   input  logic [3:0]  req_value_type,
   input  logic        req_buffer_end,
   input  logic        rsp_empty,
   input  logic        rsp_pop,
   input  logic [63:0] rsp_decoded_value,
   input  logic        rsp_is_null,
   input  logic [2:0]  rsp_status,
   input  logic [3:0]  rsp_consumed_bytes,
   output int          fail_count,
   output int          pending,
   output int          checked_count
);

   // predictor state
   bit          collecting;
   bit          pair_form;
   logic [3:0]  bytes_left;
   logic [3:0]  bytes_taken;
   logic [63:0] assembled;
   logic [3:0]  held_type;

   vid_result_type expected_values[$];
   int fails;
   int checked;

   function automatic bit is_signed_type(logic [3:0] vt);
      return vt >= VT_I8 && vt <= VT_I64;
   endfunction

   // signed checks use the wrapped 64-bit sum; the block tests the upper bits instead
   function automatic vid_status_type range_verdict(logic [3:0] vt, logic [63:0] v);
      case (vt)
         VT_BOOL: begin
            if (v > 64'hFF) return ST_RANGE;
            return (v > 64'd1) ? ST_BOOL : ST_OK;
         end
         VT_U8:  return (v > 64'hFF) ? ST_RANGE : ST_OK;
         VT_U16: return (v > 64'hFFFF) ? ST_RANGE : ST_OK;
         VT_U32: return (v > 64'hFFFF_FFFF) ? ST_RANGE : ST_OK;
         VT_I8:  return ((v + 64'h80) > 64'hFF) ? ST_RANGE : ST_OK;
         VT_I16: return ((v + 64'h8000) > 64'hFFFF) ? ST_RANGE : ST_OK;
         VT_I32: return ((v + 64'h8000_0000) > 64'hFFFF_FFFF) ? ST_RANGE : ST_OK;
         default: return ST_OK;
      endcase
   endfunction

   task automatic go_idle();
      collecting  = 1'b0;
      pair_form   = 1'b0;
      bytes_left  = '0;
      bytes_taken = '0;
      assembled   = '0;
   endtask

   always @(posedge clock) begin
      vid_result_type want;
      vid_result_type made;
      bit             emit;
      logic [63:0]    v;
      int             n;
      if (reset) begin
         go_idle();
         held_type = '0;
         expected_values.delete();
      end else begin
         // results first: nothing popped now can come from this edge's byte
         if (rsp_pop && !rsp_empty) begin
            if (expected_values.size() == 0) begin
               fails++;
               if (fails <= 10)
                  $display("%0t: unexpected result, value %h null %b status %0d bytes %0d",
                           $time, rsp_decoded_value, rsp_is_null, rsp_status,
                           rsp_consumed_bytes);
            end else begin
               want = expected_values.pop_front();
               checked++;
               if (rsp_decoded_value !== want.value || rsp_is_null !== want.is_null ||
                   rsp_status !== want.status || rsp_consumed_bytes !== want.consumed) begin
                  fails++;
                  if (fails <= 10)
                     $display("%0t: mismatch, exp %h/%b/%0d/%0d got %h/%b/%0d/%0d",
                              $time, want.value, want.is_null, want.status,
                              want.consumed, rsp_decoded_value, rsp_is_null,
                              rsp_status, rsp_consumed_bytes);
               end
            end
         end

         if (req_push && !req_full) begin
            emit = 1'b0;
            made = '0;
            if (!collecting) begin
               held_type = req_value_type;
               if (req_in_byte < 8'h80) begin
                  v = {57'b0, req_in_byte[6:0]};
                  if (is_signed_type(req_value_type) && req_in_byte[6]) v |= ExtMaskShort;
                  made.value    = v;
                  made.status   = range_verdict(req_value_type, v);
                  made.consumed = 4'd1;
                  emit = 1'b1;
               end else if (req_in_byte == LeadNull) begin
                  made.is_null  = 1'b1;
                  made.status   = ST_OK;
                  made.consumed = 4'd1;
                  emit = 1'b1;
               end else if (req_buffer_end) begin
                  // truncation wins over a bad length
                  made.status   = ST_TRUNC;
                  made.consumed = 4'd1;
                  emit = 1'b1;
               end else if (req_in_byte < 8'hC0) begin
                  collecting  = 1'b1;
                  pair_form   = 1'b1;
                  bytes_left  = 4'd1;
                  bytes_taken = 4'd1;
                  assembled   = {58'b0, req_in_byte[5:0]};
               end else if (req_in_byte[5:0] > LeadMaxN) begin
                  made.status   = ST_LEAD;
                  made.consumed = 4'd1;
                  emit = 1'b1;
               end else begin
                  collecting  = 1'b1;
                  pair_form   = 1'b0;
                  bytes_left  = 4'(req_in_byte[5:0]);
                  bytes_taken = 4'd1;
                  assembled   = '0;
               end
            end else if (pair_form) begin
               v = assembled | ({56'b0, req_in_byte} << 6);
               if (is_signed_type(held_type) && req_in_byte[7]) v |= ExtMaskPair;
               made.value    = v;
               made.status   = range_verdict(held_type, v);
               made.consumed = 4'd2;
               emit = 1'b1;
               go_idle();
            end else begin
               assembled   |= {56'b0, req_in_byte} << (8 * int'(3'(bytes_taken - 4'd1)));
               bytes_taken += 4'd1;
               bytes_left  -= 4'd1;
               if (bytes_left == 0) begin
                  n = int'(bytes_taken) - 1;
                  v = assembled;
                  if (is_signed_type(held_type) && req_in_byte[7] && n < 8)
                     v |= {64{1'b1}} << (8 * n);
                  made.value    = v;
                  made.status   = range_verdict(held_type, v);
                  made.consumed = bytes_taken;
                  emit = 1'b1;
                  go_idle();
               end else if (req_buffer_end) begin
                  made.status   = ST_TRUNC;
                  made.consumed = bytes_taken;
                  emit = 1'b1;
                  go_idle();
               end
            end
            if (emit) expected_values.push_back(made);
         end
      end
      fail_count    <= fails;
      pending       <= expected_values.size();
      checked_count <= checked;
   end

endmodule

// ===== dv/tb_top.sv =====
// Top of the compact integer stream decoder testbench: clock, reset, request
// stimulus and result-side pop driver, plus the verdict.
// Depends on vid_pkg, vlc_integer_stream_decoder_core and vid_decode_checker.

module tb_top;
   import vid_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;

   logic        req_push = 1'b0;
   logic        req_full;
   logic [7:0]  req_in_byte = '0;
   logic [3:0]  req_value_type = '0;
   logic        req_buffer_end = 1'b0;

   logic        rsp_empty;
   logic        rsp_pop = 1'b0;
   logic [63:0] rsp_decoded_value;
   logic        rsp_is_null;
   logic [2:0]  rsp_status;
   logic [3:0]  rsp_consumed_bytes;

   int fail_count;
   int pending;
   int checked_count;

   // When set, neither side idles: back-to-back requests, pop held high.
   bit no_idle = 1'b0;
   int bytes_sent = 0;

   always #2 clock = ~clock;

   vlc_integer_stream_decoder_core DUT (
      .clock              (clock),
      .reset              (reset),
      .req_push           (req_push),
      .req_full           (req_full),
      .req_in_byte        (req_in_byte),
      .req_value_type     (req_value_type),
      .req_buffer_end     (req_buffer_end),
      .rsp_empty          (rsp_empty),
      .rsp_pop            (rsp_pop),
      .rsp_decoded_value  (rsp_decoded_value),
      .rsp_is_null        (rsp_is_null),
      .rsp_status         (rsp_status),
      .rsp_consumed_bytes (rsp_consumed_bytes)
   );

   vid_decode_checker decode_check (
      .clock              (clock),
      .reset              (reset),
      .req_push           (req_push),
      .req_full           (req_full),
      .req_in_byte        (req_in_byte),
      .req_value_type     (req_value_type),
      .req_buffer_end     (req_buffer_end),
      .rsp_empty          (rsp_empty),
      .rsp_pop            (rsp_pop),
      .rsp_decoded_value  (rsp_decoded_value),
      .rsp_is_null        (rsp_is_null),
      .rsp_status         (rsp_status),
      .rsp_consumed_bytes (rsp_consumed_bytes),
      .fail_count         (fail_count),
      .pending            (pending),
      .checked_count      (checked_count)
   );

   // Result side: after each taken result, draw a random stall.
   // pop drops for the stall and comes back on its own; one NBA per edge.
   int pop_wait = 0;
   always @(posedge clock) begin
      int stall;
      if (reset) begin
         rsp_pop  <= 1'b0;
         pop_wait <= 0;
      end else if (rsp_pop && !rsp_empty) begin
         stall = no_idle ? 0 : $urandom_range(0, 8);
         pop_wait <= stall;
         rsp_pop  <= (stall == 0);
      end else if (pop_wait != 0) begin
         pop_wait <= pop_wait - 1;
         rsp_pop  <= (pop_wait == 1);
      end else begin
         rsp_pop <= 1'b1;
      end
   end

   // One request: optional gap, then hold push until an edge with full low.
   // push stays high on return so the next request can follow with no gap.
   task automatic push_stream_byte(logic [7:0] b, logic [3:0] vt, logic last);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 8);
      if (gap != 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push       <= 1'b1;
      req_in_byte    <= b;
      req_value_type <= vt;
      req_buffer_end <= last;
      do @(posedge clock); while (req_full);
      bytes_sent++;
   endtask

   // Data bytes lean toward the values that sit on range and sign edges.
   function automatic logic [7:0] pick_data_byte();
      case ($urandom_range(0, 7))
         0: return 8'h00;
         1: return 8'hFF;
         2: return 8'h7F;
         3: return 8'h80;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // One encoded value, mostly well formed, some bad leads and cut-off values.
   task automatic send_random_value();
      logic [7:0] stream[9];
      logic [3:0] vt;
      int         len;
      int         cut;
      int         pick;
      int         n;
      vt   = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(9, 15))
                                         : 4'($urandom_range(0, 8));
      pick = $urandom_range(0, 99);
      cut  = -1;
      if (pick < 20) begin
         stream[0] = 8'($urandom_range(0, 8'h7F));
         len = 1;
      end else if (pick < 40) begin
         stream[0] = 8'h80 | 8'($urandom_range(0, 8'h3F));
         stream[1] = pick_data_byte();
         len = 2;
      end else if (pick < 47) begin
         stream[0] = LeadNull;
         len = 1;
      end else if (pick < 85) begin
         n = $urandom_range(1, MaxDataBytes);
         stream[0] = LeadNull + 8'(n);
         for (int i = 1; i <= n; i++) stream[i] = pick_data_byte();
         len = n + 1;
      end else if (pick < 92) begin
         stream[0] = 8'($urandom_range(8'hC9, 8'hFF));
         len = 1;
      end else begin
         // truncated: buffer end lands before the final data byte
         if ($urandom_range(0, 2) == 0) begin
            stream[0] = 8'h80 | 8'($urandom_range(0, 8'h3F));
            len = 2;
         end else begin
            n = $urandom_range(1, MaxDataBytes);
            stream[0] = LeadNull + 8'(n);
            len = n + 1;
         end
         for (int i = 1; i < len; i++) stream[i] = pick_data_byte();
         cut = $urandom_range(0, len - 2);
         len = cut + 1;
      end
      for (int i = 0; i < len; i++) begin
         // value type only matters on the lead; elsewhere it is noise
         push_stream_byte(stream[i], (i == 0) ? vt : 4'($urandom_range(0, 15)),
                          (i == cut) || (i == len - 1 && cut < 0 && $urandom_range(0, 1)));
      end
   endtask

   initial begin
      int drain_wait;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed: short form edges, bool, null, two-byte, bad lead,
      // truncation at the lead and mid-value, long form, unknown type.
      push_stream_byte(8'h00, VT_U8,   1'b0);
      push_stream_byte(8'h7F, VT_I8,   1'b0);   // sign bit of short form
      push_stream_byte(8'h02, VT_BOOL, 1'b0);   // bad boolean
      push_stream_byte(8'hC0, VT_I64,  1'b1);   // null, buffer end ignored
      push_stream_byte(8'hBF, VT_I16,  1'b0);   // two-byte, negative
      push_stream_byte(8'hFF, VT_U8,   1'b0);
      push_stream_byte(8'hC9, VT_U64,  1'b0);   // one data byte too many
      push_stream_byte(8'h85, VT_U16,  1'b1);   // truncated at lead
      push_stream_byte(8'hC1, VT_I8,   1'b0);   // -128, just in range
      push_stream_byte(8'h80, VT_BOOL, 1'b0);
      push_stream_byte(8'hC2, VT_I8,   1'b0);   // -32768 as i8: out of range
      push_stream_byte(8'h00, VT_U8,   1'b0);
      push_stream_byte(8'h80, VT_U8,   1'b0);
      push_stream_byte(8'hC8, VT_I64,  1'b0);   // full eight bytes, no extension
      for (int i = 0; i < 8; i++) push_stream_byte(8'hFF, VT_U32, 1'b0);
      push_stream_byte(8'h7F, 4'hF,    1'b0);   // unknown type decodes as u64
      push_stream_byte(8'hC3, VT_U32,  1'b0);
      push_stream_byte(8'h11, VT_U32,  1'b1);   // truncated mid-value

      // Random streams in phases; every third phase has no idling at all.
      while (bytes_sent < 425) begin
         no_idle <= ((bytes_sent / 60) % 3 == 1);
         send_random_value();
      end
      req_push <= 1'b0;

      // the expected count is registered and lags; let it settle, then drain
      repeat (2) @(posedge clock);
      drain_wait = 0;
      while (pending != 0 && drain_wait < 5000) begin
         @(posedge clock);
         drain_wait++;
      end
      // margin for the block's latency and for anything stray
      repeat (10) @(posedge clock);

      $display("Run covered %0d stream bytes (directed edges, then random values,",
               bytes_sent);
      $display("bad leads and cut-off streams) and %0d checked results.", checked_count);
      if (fail_count == 0 && pending == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run.
   initial begin
      #2000000;
      $display("TEST FAILED");
      $finish;
   end

endmodule
